// ===== hw/rtl/rccr_pkg.sv =====
// shared widths, defaults and the front-to-back queue entry
// for the rectangle/circle collision resolver; no dependencies
package rccr_pkg;

	localparam int COORD_W      = 24;
	localparam int SIZE_W       = 23;
	localparam int D2_W         = 2 * SIZE_W;
	localparam int FRAC_BITS_DEF = 8;
	localparam int QDEPTH_DEF   = 4;

	// classified check waiting for the back end
	typedef struct packed {
		logic                      hit;
		logic                      solid;
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic [SIZE_W-1:0]         r;
		logic                      neg_x;
		logic [SIZE_W-1:0]         mag_x;
		logic                      neg_y;
		logic [SIZE_W-1:0]         mag_y;
		logic [D2_W-1:0]           dist2;
	} q_entry_t;

endpackage

// ===== hw/rtl/rccr_front.sv =====
// front end: nearest point clamp, squared distance, hit compare
// depends on rccr_pkg
module rccr_front import rccr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic [SIZE_W-1:0]         rect_w,
	input  logic [SIZE_W-1:0]         rect_h,
	input  logic signed [COORD_W-1:0] circle_x,
	input  logic signed [COORD_W-1:0] circle_y,
	input  logic [SIZE_W-1:0]         radius,
	input  logic                      solid,
	output logic                      q_push,
	input  logic                      q_full,
	output q_entry_t                  q_data
);

	logic                      en;
	logic                      v_s1, v_s2;
	logic signed [25:0]        dx_s1, dy_s1;
	logic signed [COORD_W-1:0] rx_s1, ry_s1, rx_s2, ry_s2;
	logic [SIZE_W-1:0]         r_s1;
	logic                      solid_s1, solid_s2;
	logic [49:0]               sqx_s2, sqy_s2;
	logic [D2_W-1:0]           r2_s2;
	logic                      negx_s2, negy_s2;
	logic [SIZE_W-1:0]         magx_s2, magy_s2, r_s2;

	logic signed [24:0] right, bottom, cx, cy, rx, ry, px, py;
	logic signed [25:0] ax, ay;
	logic [50:0]        d2;

	assign en     = !v_s2 || !q_full;
	assign full   = !en;
	assign q_push = v_s2 && !q_full;

	// clamp the center into the rectangle
	always_comb begin
		rx     = {rect_x[23], rect_x};
		ry     = {rect_y[23], rect_y};
		cx     = {circle_x[23], circle_x};
		cy     = {circle_y[23], circle_y};
		right  = rx + $signed({2'b00, rect_w});
		bottom = ry + $signed({2'b00, rect_h});
		px = (cx < rx) ? rx : ((cx > right) ? right : cx);
		py = (cy < ry) ? ry : ((cy > bottom) ? bottom : cy);
	end

	// magnitudes for squaring
	always_comb begin
		ax = dx_s1[25] ? -dx_s1 : dx_s1;
		ay = dy_s1[25] ? -dy_s1 : dy_s1;
	end

	// squared distance and hit
	always_comb begin
		d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		q_data.hit   = d2 < {5'b0, r2_s2};
		q_data.solid = solid_s2;
		q_data.rx    = rx_s2;
		q_data.ry    = ry_s2;
		q_data.r     = r_s2;
		q_data.neg_x = negx_s2;
		q_data.mag_x = magx_s2;
		q_data.neg_y = negy_s2;
		q_data.mag_y = magy_s2;
		q_data.dist2 = d2[D2_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= {cx[24], cx} - {px[24], px};
			dy_s1    <= {cy[24], cy} - {py[24], py};
			rx_s1    <= rect_x;
			ry_s1    <= rect_y;
			r_s1     <= radius;
			solid_s1 <= solid;
			sqx_s2   <= ax[24:0] * ax[24:0];
			sqy_s2   <= ay[24:0] * ay[24:0];
			r2_s2    <= r_s1 * r_s1;
			negx_s2  <= dx_s1[25];
			negy_s2  <= dy_s1[25];
			magx_s2  <= ax[SIZE_W-1:0];
			magy_s2  <= ay[SIZE_W-1:0];
			rx_s2    <= rx_s1;
			ry_s2    <= ry_s1;
			r_s2     <= r_s1;
			solid_s2 <= solid_s1;
		end
	end

endmodule

// ===== hw/rtl/rccr_queue.sv =====
// short queue between front and back ends
// depends on rccr_pkg
module rccr_queue import rccr_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  q_entry_t wdata,
	input  logic     pop,
	output logic     empty,
	output q_entry_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

endmodule

// ===== hw/rtl/rccr_back.sv =====
// back end: pipelined square root, push amount divide, saturation
// depends on rccr_pkg
module rccr_back import rccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	output logic                      q_pop,
	input  q_entry_t                  q_data,
	output logic                      empty,
	input  logic                      pop,
	output logic                      hit,
	output logic signed [COORD_W-1:0] new_x,
	output logic signed [COORD_W-1:0] new_y
);

	localparam int NS = SIZE_W;
	localparam logic [SIZE_W-1:0] ONE = SIZE_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic                      hit;
		logic                      solid;
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic [SIZE_W-1:0]         r;
		logic                      neg_x;
		logic [SIZE_W-1:0]         mag_x;
		logic                      neg_y;
		logic [SIZE_W-1:0]         mag_y;
		logic [D2_W-1:0]           x;
		logic [SIZE_W:0]           rem;
		logic [SIZE_W-1:0]         root;
	} sq_t;

	typedef struct packed {
		logic                      hit;
		logic                      act;
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic [SIZE_W-1:0]         d;
		logic                      add_x;
		logic                      add_y;
		logic [SIZE_W-1:0]         mx;
		logic [SIZE_W-1:0]         my;
		logic [SIZE_W-1:0]         ov;
	} pr_t;

	typedef struct packed {
		logic                      hit;
		logic                      act;
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic [SIZE_W-1:0]         d;
		logic                      add_x;
		logic                      add_y;
		logic [SIZE_W-1:0]         lowx;
		logic [SIZE_W-1:0]         remx;
		logic [SIZE_W-1:0]         qx;
		logic [SIZE_W-1:0]         lowy;
		logic [SIZE_W-1:0]         remy;
		logic [SIZE_W-1:0]         qy;
	} dv_t;

	logic en;
	logic [NS:0] sq_v, dv_v;
	sq_t  sq [NS+1];
	sq_t  sq_n [NS];
	dv_t  dv [NS+1];
	dv_t  dv_n [NS];
	logic p1_v, p2_v, out_v_q;
	pr_t  p1_s, p1_n;
	logic [D2_W-1:0] nx_p2, ny_p2;
	pr_t  p2_s;
	dv_t  dv0_n;

	assign en    = !out_v_q || pop;
	assign q_pop = en && !q_empty;
	assign empty = !out_v_q;

	// one root bit per stage
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		logic [SIZE_W+2:0] cur, trial;
		always_comb begin
			cur   = {sq[k].rem, sq[k].x[D2_W-1 -: 2]};
			trial = {1'b0, sq[k].root, 2'b01};
			sq_n[k]   = sq[k];
			sq_n[k].x = {sq[k].x[D2_W-3:0], 2'b00};
			if (cur >= trial) begin
				sq_n[k].rem  = (SIZE_W+1)'(cur - trial);
				sq_n[k].root = {sq[k].root[SIZE_W-2:0], 1'b1};
			end else begin
				sq_n[k].rem  = cur[SIZE_W:0];
				sq_n[k].root = {sq[k].root[SIZE_W-2:0], 1'b0};
			end
		end
	end

	// zero distance fix-up, overlap and push direction
	always_comb begin
		logic signed [SIZE_W:0] ovs;
		logic                   zero, ovneg, nxs, nys;
		zero  = (sq[NS].root == '0);
		p1_n.hit = sq[NS].hit;
		p1_n.act = sq[NS].hit && sq[NS].solid;
		p1_n.rx  = sq[NS].rx;
		p1_n.ry  = sq[NS].ry;
		p1_n.d   = zero ? ONE : sq[NS].root;
		p1_n.mx  = zero ? ONE : sq[NS].mag_x;
		p1_n.my  = zero ? '0 : sq[NS].mag_y;
		nxs      = zero ? 1'b0 : sq[NS].neg_x;
		nys      = zero ? 1'b0 : sq[NS].neg_y;
		ovs      = $signed({1'b0, sq[NS].r}) - $signed({1'b0, p1_n.d});
		ovneg    = ovs[SIZE_W];
		p1_n.ov  = ovneg ? SIZE_W'(-ovs) : ovs[SIZE_W-1:0];
		p1_n.add_x = nxs ^ ovneg;
		p1_n.add_y = nys ^ ovneg;
	end

	// divide setup: quotient is known to fit the low half
	always_comb begin
		dv0_n.hit   = p2_s.hit;
		dv0_n.act   = p2_s.act;
		dv0_n.rx    = p2_s.rx;
		dv0_n.ry    = p2_s.ry;
		dv0_n.d     = p2_s.d;
		dv0_n.add_x = p2_s.add_x;
		dv0_n.add_y = p2_s.add_y;
		dv0_n.remx  = nx_p2[D2_W-1:SIZE_W];
		dv0_n.lowx  = nx_p2[SIZE_W-1:0];
		dv0_n.qx    = '0;
		dv0_n.remy  = ny_p2[D2_W-1:SIZE_W];
		dv0_n.lowy  = ny_p2[SIZE_W-1:0];
		dv0_n.qy    = '0;
	end

	// one quotient bit per stage, both axes
	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [SIZE_W:0] cx, cy, dd;
		always_comb begin
			dd = {1'b0, dv[k].d};
			cx = {dv[k].remx, dv[k].lowx[SIZE_W-1]};
			cy = {dv[k].remy, dv[k].lowy[SIZE_W-1]};
			dv_n[k]      = dv[k];
			dv_n[k].lowx = {dv[k].lowx[SIZE_W-2:0], 1'b0};
			dv_n[k].lowy = {dv[k].lowy[SIZE_W-2:0], 1'b0};
			if (cx >= dd) begin
				dv_n[k].remx = SIZE_W'(cx - dd);
				dv_n[k].qx   = {dv[k].qx[SIZE_W-2:0], 1'b1};
			end else begin
				dv_n[k].remx = cx[SIZE_W-1:0];
				dv_n[k].qx   = {dv[k].qx[SIZE_W-2:0], 1'b0};
			end
			if (cy >= dd) begin
				dv_n[k].remy = SIZE_W'(cy - dd);
				dv_n[k].qy   = {dv[k].qy[SIZE_W-2:0], 1'b1};
			end else begin
				dv_n[k].remy = cy[SIZE_W-1:0];
				dv_n[k].qy   = {dv[k].qy[SIZE_W-2:0], 1'b0};
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] move_sat(
		input logic signed [COORD_W-1:0] base,
		input logic [SIZE_W-1:0] q,
		input logic add
	);
		logic signed [COORD_W+1:0] s;
		s = add ? ($signed({{2{base[COORD_W-1]}}, base}) + $signed({3'b000, q}))
			: ($signed({{2{base[COORD_W-1]}}, base}) - $signed({3'b000, q}));
		if (s > $signed((COORD_W+2)'(8388607)))
			return COORD_W'(8388607);
		else if (s < -$signed((COORD_W+2)'(8388608)))
			return COORD_W'(-8388608);
		else
			return s[COORD_W-1:0];
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v    <= '0;
			dv_v    <= '0;
			p1_v    <= 1'b0;
			p2_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			sq_v    <= {sq_v[NS-1:0], q_pop};
			p1_v    <= sq_v[NS];
			p2_v    <= p1_v;
			dv_v    <= {dv_v[NS-1:0], p2_v};
			out_v_q <= dv_v[NS];
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			sq[0].hit   <= q_data.hit;
			sq[0].solid <= q_data.solid;
			sq[0].rx    <= q_data.rx;
			sq[0].ry    <= q_data.ry;
			sq[0].r     <= q_data.r;
			sq[0].neg_x <= q_data.neg_x;
			sq[0].mag_x <= q_data.mag_x;
			sq[0].neg_y <= q_data.neg_y;
			sq[0].mag_y <= q_data.mag_y;
			sq[0].x     <= q_data.dist2;
			sq[0].rem   <= '0;
			sq[0].root  <= '0;
			for (int k = 0; k < NS; k++) begin
				sq[k+1] <= sq_n[k];
				dv[k+1] <= dv_n[k];
			end
			p1_s  <= p1_n;
			p2_s  <= p1_s;
			nx_p2 <= p1_s.mx * p1_s.ov;
			ny_p2 <= p1_s.my * p1_s.ov;
			dv[0] <= dv0_n;
			hit   <= dv[NS].hit;
			new_x <= dv[NS].act ? move_sat(dv[NS].rx, dv[NS].qx, dv[NS].add_x) : dv[NS].rx;
			new_y <= dv[NS].act ? move_sat(dv[NS].ry, dv[NS].qy, dv[NS].add_y) : dv[NS].ry;
		end
	end

endmodule

// ===== hw/rtl/rect_circle_collision_resolve_top.sv =====
// Circle versus axis-aligned rectangle collision check with push-out.
// Input side is a queue: drive the fields and push; a request is taken at
// a clock edge with push high and full low. Results come out as a queue:
// while empty is low the oldest result (hit, new_x, new_y) is on the
// ports and it is taken at an edge with pop high.
// One request per cycle is sustained while results are popped. A request
// passes two front stages (clamp, squares), one queue slot, the square
// root stages, two stages for overlap and products, the divide stages and
// the result register. The square root and divide each retire one bit
// per stage, which sets the depth.
// When pop stays low the back end holds, the queue between the halves
// fills, then the front holds and full rises; nothing is dropped.
// Reset clears all valid bits and queue pointers; no clearing pass.
// Coordinates are signed fixed point with FRAC_BITS fraction bits.
// depends on rccr_pkg, rccr_front, rccr_queue, rccr_back
module rect_circle_collision_resolve_top import rccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int QDEPTH    = QDEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic [SIZE_W-1:0]         rect_w,
	input  logic [SIZE_W-1:0]         rect_h,
	input  logic signed [COORD_W-1:0] circle_x,
	input  logic signed [COORD_W-1:0] circle_y,
	input  logic [SIZE_W-1:0]         radius,
	input  logic                      solid,
	output logic                      empty,
	input  logic                      pop,
	output logic                      hit,
	output logic signed [COORD_W-1:0] new_x,
	output logic signed [COORD_W-1:0] new_y
);

	logic     f_push, f_full, b_pop, b_empty;
	q_entry_t f_data, b_data;

	// classify
	rccr_front u_front (
		.clk, .arst_n, .push, .full,
		.rect_x, .rect_y, .rect_w, .rect_h,
		.circle_x, .circle_y, .radius, .solid,
		.q_push(f_push), .q_full(f_full), .q_data(f_data)
	);

	// decoupling queue
	rccr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n,
		.push(f_push), .full(f_full), .wdata(f_data),
		.pop(b_pop), .empty(b_empty), .rdata(b_data)
	);

	// resolve
	rccr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.q_empty(b_empty), .q_pop(b_pop), .q_data(b_data),
		.empty, .pop, .hit, .new_x, .new_y
	);

endmodule
